### hdl/lds_pkg.sv
// shared constants and controller/datapath interface types for the diophantine solver
// no dependencies
`default_nettype none
package lds_pkg;
  localparam int FIELD_W      = 32;
  localparam int SOL_W        = 64;
  localparam int IN_WIDTH_DEF = 32;

  typedef struct packed {
    logic load;
    logic euc_init;
    logic fin_init;
    logic div_step;
    logic euc_update;
    logic out_load;
  } lds_cmd_t;

  typedef struct packed {
    logic u_zero;
    logic step_last;
  } lds_stat_t;
endpackage
`default_nettype wire

### hdl/lds_ctrl.sv
// sequencer for the euclid loop, final division and output register handshake
// depends on lds_pkg
`default_nettype none
module lds_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output lds_pkg::lds_cmd_t      cmd,
  input  wire lds_pkg::lds_stat_t stat
);
  typedef enum logic [2:0] {S_IDLE, S_CHK, S_DIV, S_UPD, S_FIN, S_OUT} state_t;
  state_t state;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd = '0;
    case (state)
      S_IDLE: cmd.load = in_valid;
      S_CHK: begin
        cmd.euc_init = !stat.u_zero;
        cmd.fin_init = stat.u_zero;
      end
      S_DIV:   cmd.div_step = 1'b1;
      S_UPD:   cmd.euc_update = 1'b1;
      S_FIN:   cmd.div_step = 1'b1;
      S_OUT:   cmd.out_load = out_free;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == S_OUT && out_free) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: if (in_valid) state <= S_CHK;
        S_CHK:  state <= stat.u_zero ? S_FIN : S_DIV;
        S_DIV:  if (stat.step_last) state <= S_UPD;
        S_UPD:  state <= S_CHK;
        S_FIN:  if (stat.step_last) state <= S_OUT;
        S_OUT:  if (out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

### hdl/lds_dp.sv
// datapath: bit-serial divider with horner accumulators for bezout rows and scaling
// depends on lds_pkg
`default_nettype none
module lds_dp #(
  parameter int IN_WIDTH = lds_pkg::IN_WIDTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic [lds_pkg::FIELD_W-1:0]         coef_a,
  input  wire logic [lds_pkg::FIELD_W-1:0]         coef_b,
  input  wire logic [lds_pkg::FIELD_W-1:0]         rhs_c,
  input  wire lds_pkg::lds_cmd_t                   cmd,
  output lds_pkg::lds_stat_t                       stat,
  output logic                                     solvable,
  output logic signed [lds_pkg::SOL_W-1:0]         sol_x,
  output logic signed [lds_pkg::SOL_W-1:0]         sol_y,
  output logic [lds_pkg::FIELD_W-1:0]              divisor_g
);
  localparam int W  = IN_WIDTH;
  localparam int CW = $clog2(W);
  localparam int SW = lds_pkg::SOL_W;

  logic [W-1:0]  u, v, cm, num, den, rem;
  logic [SW-1:0] r0x, r0y, r1x, r1y, tx, ty;
  logic [CW-1:0] cnt;
  logic          sa, sb, sc, cz, fin;

  logic [W-1:0]  a_s, b_s, c_s, shifted;
  logic          qbit, rem_zero, g_zero;
  logic [SW-1:0] mx, my;

  assign a_s      = coef_a[W-1:0];
  assign b_s      = coef_b[W-1:0];
  assign c_s      = rhs_c[W-1:0];
  assign shifted  = {rem[W-2:0], num[W-1]};
  assign qbit     = (shifted >= den);
  assign mx       = fin ? r1x : r0x;
  assign my       = fin ? r1y : r0y;
  assign rem_zero = (rem == '0);
  assign g_zero   = (v == '0);

  assign stat.u_zero    = (u == '0);
  assign stat.step_last = (cnt == '0);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sa  <= a_s[W-1];
      sb  <= b_s[W-1];
      sc  <= c_s[W-1];
      u   <= a_s[W-1] ? (W'(0) - a_s) : a_s;
      v   <= b_s[W-1] ? (W'(0) - b_s) : b_s;
      cm  <= c_s[W-1] ? (W'(0) - c_s) : c_s;
      cz  <= (c_s == '0);
      r0x <= SW'(1);
      r0y <= '0;
      r1x <= '0;
      r1y <= SW'(1);
    end
    if (cmd.euc_init || cmd.fin_init) begin
      fin <= cmd.fin_init;
      num <= cmd.fin_init ? cm : v;
      den <= cmd.fin_init ? v : u;
      rem <= '0;
      tx  <= '0;
      ty  <= '0;
      cnt <= CW'(W - 1);
    end
    if (cmd.div_step) begin
      rem <= qbit ? (shifted - den) : shifted;
      num <= {num[W-2:0], 1'b0};
      tx  <= {tx[SW-2:0], 1'b0} + (qbit ? mx : '0);
      ty  <= {ty[SW-2:0], 1'b0} + (qbit ? my : '0);
      cnt <= cnt - 1'b1;
    end
    if (cmd.euc_update) begin
      u   <= rem;
      v   <= u;
      r0x <= r1x - tx;
      r0y <= r1y - ty;
      r1x <= r0x;
      r1y <= r0y;
    end
    if (cmd.out_load) begin
      divisor_g <= lds_pkg::FIELD_W'(v);
      if (g_zero || !rem_zero) begin
        solvable <= g_zero && cz;
        sol_x    <= '0;
        sol_y    <= '0;
      end else begin
        solvable <= 1'b1;
        sol_x    <= (sc ^ sa) ? (SW'(0) - tx) : tx;
        sol_y    <= (sc ^ sb) ? (SW'(0) - ty) : ty;
      end
    end
  end
endmodule
`default_nettype wire

### hdl/linear_diophantine_solver.sv
// top level of the linear diophantine solver: sequencer plus datapath
// depends on lds_pkg, lds_ctrl, lds_dp
//
// usage: present coef_a, coef_b, rhs_c with in_valid; the request is taken when
// in_ready is high. one result (solvable, sol_x, sol_y, divisor_g) follows on
// out_valid/out_ready for every request, in order.
// a new request is taken once the result is in the output register and the
// sequencer is back in idle.
// each euclid step is one pass of the shared bit-serial divider (one quotient
// bit per cycle) whose horner accumulators update the bezout rows alongside;
// the final c/g division scales the coefficients the same way.
// one request at a time: in_ready is high only while the sequencer is idle.
// the result sits in an output register; while the receiver stalls a new
// request is still taken and computed, and is held before the output until
// the pending result has been taken.
// reset (rst, synchronous) returns the sequencer to idle and drops out_valid.
`default_nettype none
module linear_diophantine_solver #(
  parameter int IN_WIDTH = lds_pkg::IN_WIDTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [lds_pkg::FIELD_W-1:0] coef_a,
  input  wire logic [lds_pkg::FIELD_W-1:0] coef_b,
  input  wire logic [lds_pkg::FIELD_W-1:0] rhs_c,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic                             solvable,
  output logic signed [lds_pkg::SOL_W-1:0] sol_x,
  output logic signed [lds_pkg::SOL_W-1:0] sol_y,
  output logic [lds_pkg::FIELD_W-1:0]      divisor_g
);
  lds_pkg::lds_cmd_t  cmd;
  lds_pkg::lds_stat_t stat;

  lds_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  lds_dp #(.IN_WIDTH(IN_WIDTH)) u_dp (
    .clk       (clk),
    .coef_a    (coef_a),
    .coef_b    (coef_b),
    .rhs_c     (rhs_c),
    .cmd       (cmd),
    .stat      (stat),
    .solvable  (solvable),
    .sol_x     (sol_x),
    .sol_y     (sol_y),
    .divisor_g (divisor_g)
  );
endmodule
`default_nettype wire
